@@ src/plmd_pkg.sv @@
`default_nettype none

package plmd_pkg;

    localparam int NUM_CHANNELS = 8;
    localparam int SAMPLE_BITS  = 24;

    localparam int CHAN_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CHAN_W     = 3;
    localparam int ACTIVE_W   = 4;
    localparam int DECAY_W    = 24;
    localparam int FRAMES_W   = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int LEVEL_DB_W = 17;

    localparam int MAX_OUT    = 8;
    localparam int MUL_W      = 32;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int PAD_W      = MUL_W - SAMPLE_BITS;
    localparam int SHIFT_W    = 5;
    localparam int FRAC_BITS  = 24;
    localparam int ITER_W     = 5;
    localparam int OCT_W      = SHIFT_W + FRAC_BITS;
    localparam int DPROD_W    = FRAMES_W + DECAY_W;
    localparam int MAG_W      = 33;
    localparam int LEVEL_W    = 33;
    localparam int WORK_W     = 50;
    localparam int ROUND_POS  = 24;

    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_CHANNELS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_PER_FRAME = CFG_IDX_W'(1);

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = ACTIVE_W'(2);
    localparam logic [DECAY_W-1:0]  DECAY_RESET  = DECAY_W'(4112);

    localparam logic [MUL_W-1:0]    DB_PER_OCTAVE_Q24 = MUL_W'(101008905);
    localparam logic [PROD_W-1:0]   ROUND_HALF        = PROD_W'(64'd1 << (ROUND_POS - 1));
    localparam logic signed [WORK_W-1:0] NEG_FLOOR_Q24 = -$signed(WORK_W'(64'd192 << 24));
    localparam logic [WORK_W-1:0]   Q88_HALF          = WORK_W'(32768);
    localparam logic [LEVEL_DB_W-1:0] SILENT_Q88      = LEVEL_DB_W'(49152);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECAY_MUL,
        ST_DECAY_GET,
        ST_LOAD,
        ST_NORM,
        ST_SQ_MUL,
        ST_SQ_GET,
        ST_OCTAVE,
        ST_SCALE_MUL,
        ST_ROUND,
        ST_MERGE,
        ST_FINAL
    } t_state;

    typedef enum logic [1:0] {
        MUL_SQUARE,
        MUL_SCALE,
        MUL_DECAY
    } t_mul_op;

    typedef struct packed {
        logic                en;
        t_mul_op             op;
        logic [MUL_W-1:0]    mant;
        logic [OCT_W-1:0]    octaves;
        logic [FRAMES_W-1:0] frames;
        logic [DECAY_W-1:0]  decay;
    } t_mul_req;

endpackage

`default_nettype wire

@@ src/plmd_if.sv @@
`default_nettype none

interface plmd_in_if;
    logic                                    valid;
    logic                                    ready;
    logic                                    command;
    logic [plmd_pkg::CHAN_W-1:0]             channel;
    logic signed [plmd_pkg::SAMPLE_BITS-1:0] sample;
    logic                                    frame_end;

    modport source (output valid, command, channel, sample, frame_end, input ready);
    modport sink   (input valid, command, channel, sample, frame_end, output ready);
endinterface

interface plmd_out_if;
    logic                                   valid;
    logic                                   ready;
    logic [plmd_pkg::CHAN_W-1:0]            out_channel;
    logic signed [plmd_pkg::LEVEL_DB_W-1:0] level_db;
    logic                                   silent;
    logic                                   last;

    modport source (output valid, out_channel, level_db, silent, last, input ready);
    modport sink   (input valid, out_channel, level_db, silent, last, output ready);
endinterface

interface plmd_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [plmd_pkg::CFG_IDX_W-1:0]      index;
    logic [plmd_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ src/plmd_mul.sv @@
`default_nettype none

module plmd_mul (
    input  wire logic                          i_clk,
    input  wire plmd_pkg::t_mul_req            i_req,
    output logic [plmd_pkg::PROD_W-1:0]        o_prod
);

    logic [plmd_pkg::MUL_W-1:0]  op_a;
    logic [plmd_pkg::MUL_W-1:0]  op_b;
    logic [plmd_pkg::PROD_W-1:0] r_prod;
    logic [plmd_pkg::PROD_W-1:0] n_prod;

    always_comb begin
        case (i_req.op)
            plmd_pkg::MUL_SQUARE: begin
                op_a = i_req.mant;
                op_b = i_req.mant;
            end
            plmd_pkg::MUL_SCALE: begin
                op_a = plmd_pkg::MUL_W'(i_req.octaves);
                op_b = plmd_pkg::DB_PER_OCTAVE_Q24;
            end
            plmd_pkg::MUL_DECAY: begin
                op_a = plmd_pkg::MUL_W'(i_req.frames);
                op_b = plmd_pkg::MUL_W'(i_req.decay);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign n_prod = plmd_pkg::PROD_W'(op_a) * plmd_pkg::PROD_W'(op_b);

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

@@ src/peak_level_meter_db_decay_unit.sv @@
// Channel   Direction  Carries
// i_in      sink       command, channel, sample, frame_end
// o_out     source     out_channel, level_db, silent, last
// i_cfg     sink       index, data (0 = active_channels, 1 = decay_per_frame)
//
// Samples may arrive in every cycle while no tick is being worked.
// A tick first forms the decay product on the shared multiplier; then, per reported channel,
// a zero peak goes straight to the result, while a non-zero peak runs the normalising shift,
// the squaring loop and the scaling on that multiplier, then the rounding and the merge.
// The input is not ready while a tick is being worked; the configuration port is always ready.
// A channel result waits in the output register while the sink stalls, and the walk waits too.
// Reset is synchronous and active low and clears all peaks, levels and the frame count.
`default_nettype none

module peak_level_meter_db_decay_unit (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    plmd_in_if.sink    i_in,
    plmd_out_if.source o_out,
    plmd_cfg_if.sink   i_cfg
);

    plmd_pkg::t_state r_state;
    plmd_pkg::t_state n_state;

    logic [plmd_pkg::ACTIVE_W-1:0]   r_active;
    logic [plmd_pkg::DECAY_W-1:0]    r_decay_rate;

    logic [plmd_pkg::SAMPLE_BITS-1:0]   r_peak   [plmd_pkg::NUM_CHANNELS];
    logic signed [plmd_pkg::LEVEL_W-1:0] r_level [plmd_pkg::NUM_CHANNELS];
    logic                               r_silent [plmd_pkg::NUM_CHANNELS];
    logic [plmd_pkg::FRAMES_W-1:0]      r_frames;

    logic [plmd_pkg::CHAN_IDX_W-1:0] r_ch;
    logic [plmd_pkg::CHAN_IDX_W-1:0] r_last_ch;
    logic [plmd_pkg::DPROD_W-1:0]    r_decay;
    logic [plmd_pkg::MUL_W-1:0]      r_m;
    logic [plmd_pkg::SHIFT_W-1:0]    r_shift;
    logic [plmd_pkg::ITER_W-1:0]     r_iter;
    logic [plmd_pkg::FRAC_BITS-1:0]  r_frac;
    logic [plmd_pkg::OCT_W-1:0]      r_oct;
    logic [plmd_pkg::MAG_W-1:0]      r_mag;
    logic signed [plmd_pkg::WORK_W-1:0] r_lvl;
    logic                            r_sil;

    logic                                   r_out_valid;
    logic [plmd_pkg::CHAN_W-1:0]            r_out_channel;
    logic signed [plmd_pkg::LEVEL_DB_W-1:0] r_out_level;
    logic                                   r_out_silent;
    logic                                   r_out_last;

    logic                          in_ready;
    logic                          out_free;
    logic                          out_load;
    plmd_pkg::t_mul_req            mul_req;
    logic [plmd_pkg::PROD_W-1:0]   prod;

    logic                               in_fire;
    logic [plmd_pkg::CHAN_IDX_W-1:0]    in_idx;
    logic [plmd_pkg::SAMPLE_BITS-1:0]   in_mag;
    logic [plmd_pkg::ACTIVE_W-1:0]      n_count;
    logic [plmd_pkg::MAG_W-1:0]         sq_top;
    logic [plmd_pkg::PROD_W-1:0]        rounded;
    logic signed [plmd_pkg::WORK_W-1:0] lvl_load;
    logic signed [plmd_pkg::WORK_W-1:0] merge_sum;
    logic signed [plmd_pkg::WORK_W-1:0] neg_mag;
    logic                               fin_sil;
    logic [plmd_pkg::WORK_W-1:0]        q_wide;
    logic [plmd_pkg::LEVEL_DB_W-1:0]    q_val;

    plmd_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (prod)
    );

    assign in_fire = i_in.valid && in_ready;
    assign in_idx  = plmd_pkg::CHAN_IDX_W'(i_in.channel);
    assign in_mag  = i_in.sample[plmd_pkg::SAMPLE_BITS-1]
                   ? plmd_pkg::SAMPLE_BITS'(0) - plmd_pkg::SAMPLE_BITS'(i_in.sample)
                   : plmd_pkg::SAMPLE_BITS'(i_in.sample);

    always_comb begin
        n_count = (r_active == '0) ? plmd_pkg::ACTIVE_W'(1) : r_active;
        if (32'(n_count) > plmd_pkg::NUM_CHANNELS) begin
            n_count = plmd_pkg::ACTIVE_W'(plmd_pkg::NUM_CHANNELS);
        end
        if (32'(n_count) > plmd_pkg::MAX_OUT) begin
            n_count = plmd_pkg::ACTIVE_W'(plmd_pkg::MAX_OUT);
        end
    end

    assign sq_top    = prod[plmd_pkg::PROD_W-1 -: plmd_pkg::MAG_W];
    assign rounded   = prod + plmd_pkg::ROUND_HALF;
    assign lvl_load  = r_silent[r_ch] ? plmd_pkg::WORK_W'(0)
                     : plmd_pkg::WORK_W'(r_level[r_ch])
                       - $signed(plmd_pkg::WORK_W'(r_decay));
    assign merge_sum = r_lvl + $signed(plmd_pkg::WORK_W'(r_mag));
    assign neg_mag   = plmd_pkg::WORK_W'(0) - $signed(plmd_pkg::WORK_W'(r_mag));
    assign fin_sil   = r_sil || (r_lvl <= plmd_pkg::NEG_FLOOR_Q24);
    assign q_wide    = plmd_pkg::Q88_HALF - plmd_pkg::WORK_W'(r_lvl);
    assign q_val     = fin_sil ? plmd_pkg::SILENT_Q88 : q_wide[16 +: plmd_pkg::LEVEL_DB_W];

    always_comb begin
        n_state = r_state;
        case (r_state)
            plmd_pkg::ST_IDLE: begin
                if (in_fire && i_in.command) begin
                    n_state = plmd_pkg::ST_DECAY_MUL;
                end
            end
            plmd_pkg::ST_DECAY_MUL: n_state = plmd_pkg::ST_DECAY_GET;
            plmd_pkg::ST_DECAY_GET: n_state = plmd_pkg::ST_LOAD;
            plmd_pkg::ST_LOAD: begin
                n_state = (r_peak[r_ch] == '0) ? plmd_pkg::ST_FINAL : plmd_pkg::ST_NORM;
            end
            plmd_pkg::ST_NORM: begin
                if (r_m[plmd_pkg::MUL_W-1]) begin
                    n_state = plmd_pkg::ST_SQ_MUL;
                end
            end
            plmd_pkg::ST_SQ_MUL: n_state = plmd_pkg::ST_SQ_GET;
            plmd_pkg::ST_SQ_GET: begin
                n_state = (r_iter == plmd_pkg::ITER_W'(plmd_pkg::FRAC_BITS - 1))
                        ? plmd_pkg::ST_OCTAVE : plmd_pkg::ST_SQ_MUL;
            end
            plmd_pkg::ST_OCTAVE:    n_state = plmd_pkg::ST_SCALE_MUL;
            plmd_pkg::ST_SCALE_MUL: n_state = plmd_pkg::ST_ROUND;
            plmd_pkg::ST_ROUND:     n_state = plmd_pkg::ST_MERGE;
            plmd_pkg::ST_MERGE:     n_state = plmd_pkg::ST_FINAL;
            plmd_pkg::ST_FINAL: begin
                if (out_free) begin
                    n_state = (r_ch == r_last_ch) ? plmd_pkg::ST_IDLE : plmd_pkg::ST_LOAD;
                end
            end
            default: n_state = plmd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready        = (r_state == plmd_pkg::ST_IDLE);
        out_free        = !r_out_valid || o_out.ready;
        out_load        = (r_state == plmd_pkg::ST_FINAL) && out_free;
        mul_req.en      = 1'b0;
        mul_req.op      = plmd_pkg::MUL_SQUARE;
        mul_req.mant    = r_m;
        mul_req.octaves = r_oct;
        mul_req.frames  = r_frames;
        mul_req.decay   = r_decay_rate;
        case (r_state)
            plmd_pkg::ST_DECAY_MUL: begin
                mul_req.en = 1'b1;
                mul_req.op = plmd_pkg::MUL_DECAY;
            end
            plmd_pkg::ST_SQ_MUL: begin
                mul_req.en = 1'b1;
                mul_req.op = plmd_pkg::MUL_SQUARE;
            end
            plmd_pkg::ST_SCALE_MUL: begin
                mul_req.en = 1'b1;
                mul_req.op = plmd_pkg::MUL_SCALE;
            end
            default: begin
                mul_req.en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= plmd_pkg::ST_IDLE;
            r_active     <= plmd_pkg::ACTIVE_RESET;
            r_decay_rate <= plmd_pkg::DECAY_RESET;
            r_frames     <= '0;
            r_out_valid  <= 1'b0;
            r_ch         <= '0;
            r_last_ch    <= '0;
            for (int i = 0; i < plmd_pkg::NUM_CHANNELS; i++) begin
                r_peak[i]   <= '0;
                r_level[i]  <= '0;
                r_silent[i] <= 1'b1;
            end
        end else begin
            r_state <= n_state;

            if (i_cfg.valid) begin
                if (i_cfg.index == plmd_pkg::REG_ACTIVE_CHANNELS) begin
                    r_active <= i_cfg.data[plmd_pkg::ACTIVE_W-1:0];
                end else if (i_cfg.index == plmd_pkg::REG_DECAY_PER_FRAME) begin
                    r_decay_rate <= i_cfg.data[plmd_pkg::DECAY_W-1:0];
                end
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                plmd_pkg::ST_IDLE: begin
                    if (in_fire && !i_in.command) begin
                        if (32'(i_in.channel) < plmd_pkg::NUM_CHANNELS
                                && in_mag > r_peak[in_idx]) begin
                            r_peak[in_idx] <= in_mag;
                        end
                        if (i_in.frame_end && r_frames != '1) begin
                            r_frames <= r_frames + plmd_pkg::FRAMES_W'(1);
                        end
                    end
                    if (in_fire && i_in.command) begin
                        r_ch      <= '0;
                        r_last_ch <= plmd_pkg::CHAN_IDX_W'(n_count - plmd_pkg::ACTIVE_W'(1));
                    end
                end
                plmd_pkg::ST_FINAL: begin
                    if (out_free) begin
                        r_level[r_ch]  <= fin_sil ? plmd_pkg::LEVEL_W'(0)
                                                  : plmd_pkg::LEVEL_W'(r_lvl);
                        r_silent[r_ch] <= fin_sil;
                        if (r_ch == r_last_ch) begin
                            r_frames <= '0;
                            for (int i = 0; i < plmd_pkg::NUM_CHANNELS; i++) begin
                                r_peak[i] <= '0;
                            end
                        end else begin
                            r_ch <= r_ch + plmd_pkg::CHAN_IDX_W'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            plmd_pkg::ST_DECAY_GET: begin
                r_decay <= prod[plmd_pkg::DPROD_W-1:0];
            end
            plmd_pkg::ST_LOAD: begin
                r_m     <= plmd_pkg::MUL_W'(r_peak[r_ch]) << plmd_pkg::PAD_W;
                r_shift <= '0;
                r_iter  <= '0;
                r_frac  <= '0;
                r_lvl   <= lvl_load;
                r_sil   <= r_silent[r_ch];
            end
            plmd_pkg::ST_NORM: begin
                if (!r_m[plmd_pkg::MUL_W-1]) begin
                    r_m     <= r_m << 1;
                    r_shift <= r_shift + plmd_pkg::SHIFT_W'(1);
                end
            end
            plmd_pkg::ST_SQ_GET: begin
                r_m    <= sq_top[plmd_pkg::MAG_W-1] ? sq_top[plmd_pkg::MAG_W-1:1]
                                                    : sq_top[plmd_pkg::MUL_W-1:0];
                r_frac <= {r_frac[plmd_pkg::FRAC_BITS-2:0], sq_top[plmd_pkg::MAG_W-1]};
                r_iter <= r_iter + plmd_pkg::ITER_W'(1);
            end
            plmd_pkg::ST_OCTAVE: begin
                r_oct <= {r_shift, plmd_pkg::FRAC_BITS'(0)} - plmd_pkg::OCT_W'(r_frac);
            end
            plmd_pkg::ST_ROUND: begin
                r_mag <= rounded[plmd_pkg::ROUND_POS +: plmd_pkg::MAG_W];
            end
            plmd_pkg::ST_MERGE: begin
                if (r_sil || merge_sum[plmd_pkg::WORK_W-1]) begin
                    r_lvl <= neg_mag;
                end
                r_sil <= 1'b0;
            end
            plmd_pkg::ST_FINAL: begin
                if (out_free) begin
                    r_out_channel <= plmd_pkg::CHAN_W'(r_ch);
                    r_out_level   <= $signed(plmd_pkg::LEVEL_DB_W'(0) - q_val);
                    r_out_silent  <= fin_sil;
                    r_out_last    <= (r_ch == r_last_ch);
                end
            end
            default: begin
            end
        endcase
    end

    assign i_in.ready        = in_ready;
    assign i_cfg.ready       = 1'b1;
    assign o_out.valid       = r_out_valid;
    assign o_out.out_channel = r_out_channel;
    assign o_out.level_db    = r_out_level;
    assign o_out.silent      = r_out_silent;
    assign o_out.last        = r_out_last;

endmodule

`default_nettype wire

@@ tb/sv/tb_peak_level_meter_db_decay_unit.sv @@
`timescale 1ns / 100ps

module tb_peak_level_meter_db_decay_unit;

    localparam int  CHANS       = (plmd_pkg::NUM_CHANNELS < plmd_pkg::MAX_OUT)
                                ? plmd_pkg::NUM_CHANNELS : plmd_pkg::MAX_OUT;
    localparam int  IDLE_LIMIT  = 4000;
    localparam int  SETTLE      = 8;
    localparam int  TAIL_CYCLES = 100;
    localparam longint FLOOR_DB = longint'(192) <<< 24;
    localparam logic [plmd_pkg::CFG_IDX_W-1:0] REG_UNUSED = plmd_pkg::CFG_IDX_W'(3);

    typedef struct {
        logic [plmd_pkg::CHAN_W-1:0]     out_channel;
        logic [plmd_pkg::LEVEL_DB_W-1:0] level_db;
        logic                            silent;
        logic                            last;
    } t_meter_result;

    class t_meter_scoreboard;
        logic [plmd_pkg::SAMPLE_BITS-1:0] peak_mag[CHANS];
        longint                           level_acc[CHANS];
        bit                               muted[CHANS];
        logic [plmd_pkg::FRAMES_W-1:0]    frames;
        logic [plmd_pkg::ACTIVE_W-1:0]    active_cfg;
        logic [plmd_pkg::DECAY_W-1:0]     decay_cfg;
        t_meter_result                    expected_levels[$];
        int errors;
        int n_samples;
        int n_ticks;
        int n_results;
        int n_silent;
        int n_writes;

        function new();
            for (int i = 0; i < CHANS; i++) begin
                peak_mag[i]  = '0;
                level_acc[i] = 0;
                muted[i]     = 1'b1;
            end
            frames     = '0;
            active_cfg = plmd_pkg::ACTIVE_RESET;
            decay_cfg  = plmd_pkg::DECAY_RESET;
            errors     = 0;
            n_samples  = 0;
            n_ticks    = 0;
            n_results  = 0;
            n_silent   = 0;
            n_writes   = 0;
        endfunction

        function int pending();
            return expected_levels.size();
        endfunction

        task report(input string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endtask

        // Level of a non-zero peak in units of 2^-24 dB.
        function longint peak_to_level(input logic [plmd_pkg::SAMPLE_BITS-1:0] p);
            int lead;
            int i;
            longint unsigned m;
            longint unsigned frac;
            longint unsigned mag;
            lead = 0;
            for (i = 0; i < plmd_pkg::SAMPLE_BITS; i++)
                if (p[i]) lead = i;
            m = longint'(p) << (31 - lead);
            frac = 0;
            for (i = 0; i < plmd_pkg::FRAC_BITS; i++) begin
                m = (m * m) >> 31;
                frac = frac << 1;
                if (m >= (64'd1 << 32)) begin
                    frac = frac | 64'd1;
                    m = m >> 1;
                end
            end
            mag = (longint'(plmd_pkg::SAMPLE_BITS - 1 - lead) << 24) - frac;
            mag = (mag * longint'(plmd_pkg::DB_PER_OCTAVE_Q24) + (64'd1 << 23)) >> 24;
            return -longint'(mag);
        endfunction

        task note_config(input logic [plmd_pkg::CFG_IDX_W-1:0] idx,
                         input logic [plmd_pkg::CFG_DATA_W-1:0] data);
            n_writes++;
            if (idx == plmd_pkg::REG_ACTIVE_CHANNELS)
                active_cfg = data[plmd_pkg::ACTIVE_W-1:0];
            else if (idx == plmd_pkg::REG_DECAY_PER_FRAME)
                decay_cfg = data[plmd_pkg::DECAY_W-1:0];
        endtask

        task note_item(input logic cmd, input logic [plmd_pkg::CHAN_W-1:0] ch,
                       input logic signed [plmd_pkg::SAMPLE_BITS-1:0] smp, input logic fe);
            logic [plmd_pkg::SAMPLE_BITS-1:0] mag;
            int n;
            int c;
            bit mute;
            longint lvl;
            longint pdb;
            longint unsigned q;
            t_meter_result res;
            if (cmd == 1'b0) begin
                n_samples++;
                mag = smp[plmd_pkg::SAMPLE_BITS-1] ? (~smp + 1'b1) : smp;
                if (int'(ch) < CHANS && mag > peak_mag[ch])
                    peak_mag[ch] = mag;
                if (fe && frames != {plmd_pkg::FRAMES_W{1'b1}})
                    frames = frames + 1'b1;
            end else begin
                n_ticks++;
                n = (active_cfg == 0) ? 1
                  : (int'(active_cfg) > CHANS) ? CHANS : int'(active_cfg);
                for (c = 0; c < n; c++) begin
                    mute = muted[c];
                    lvl = 0;
                    q = longint'(plmd_pkg::SILENT_Q88);
                    if (!mute)
                        lvl = level_acc[c] - longint'(frames) * longint'(decay_cfg);
                    if (peak_mag[c] != 0) begin
                        pdb = peak_to_level(peak_mag[c]);
                        if (mute || pdb > lvl)
                            lvl = pdb;
                        mute = 1'b0;
                    end
                    if (!mute && lvl <= -FLOOR_DB)
                        mute = 1'b1;
                    if (mute) begin
                        level_acc[c] = 0;
                        muted[c] = 1'b1;
                    end else begin
                        level_acc[c] = lvl;
                        muted[c] = 1'b0;
                        q = $unsigned(-lvl) + 64'd32768;
                        q = q >> 16;
                    end
                    res.out_channel = plmd_pkg::CHAN_W'(c);
                    res.level_db    = plmd_pkg::LEVEL_DB_W'(64'd0 - q);
                    res.silent      = mute;
                    res.last        = (c + 1 == n);
                    expected_levels.push_back(res);
                end
                for (c = 0; c < CHANS; c++)
                    peak_mag[c] = '0;
                frames = '0;
            end
        endtask

        task check_result(input logic [plmd_pkg::CHAN_W-1:0] ch,
                          input logic [plmd_pkg::LEVEL_DB_W-1:0] lvl,
                          input logic sil, input logic lst);
            t_meter_result exp_r;
            if (expected_levels.size() == 0) begin
                report($sformatf("unexpected result ch=%0d level=%0d silent=%0b last=%0b",
                                 ch, $signed(lvl), sil, lst));
            end else begin
                exp_r = expected_levels.pop_front();
                n_results++;
                if (exp_r.silent) n_silent++;
                if (ch !== exp_r.out_channel)
                    report($sformatf("out_channel %0d, expected %0d", ch, exp_r.out_channel));
                if (lvl !== exp_r.level_db)
                    report($sformatf("ch %0d level_db %0d, expected %0d", exp_r.out_channel,
                                     $signed(lvl), $signed(exp_r.level_db)));
                if (sil !== exp_r.silent)
                    report($sformatf("ch %0d silent %0b, expected %0b", exp_r.out_channel,
                                     sil, exp_r.silent));
                if (lst !== exp_r.last)
                    report($sformatf("ch %0d last %0b, expected %0b", exp_r.out_channel,
                                     lst, exp_r.last));
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   steady;
    int   sink_hold;
    int   quiet_cycles;
    t_meter_scoreboard sb;

    plmd_in_if  in_if ();
    plmd_out_if out_if ();
    plmd_cfg_if cfg_if ();

    peak_level_meter_db_decay_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always #10 clk = ~clk;

    function automatic int idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(25, 70);
    endfunction

    function automatic logic signed [plmd_pkg::SAMPLE_BITS-1:0] pick_sample();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return {1'b0, {(plmd_pkg::SAMPLE_BITS-1){1'b1}}};
        if (r < 10)
            return {1'b1, {(plmd_pkg::SAMPLE_BITS-1){1'b0}}};
        if (r < 15)
            return plmd_pkg::SAMPLE_BITS'($signed($urandom_range(0, 6)) - 3);
        if (r < 55)
            return plmd_pkg::SAMPLE_BITS'($urandom);
        return plmd_pkg::SAMPLE_BITS'($signed($urandom) >>> $urandom_range(8, 31));
    endfunction

    always @(posedge clk) begin
        if (sink_hold != 0) begin
            sink_hold <= sink_hold - 1;
        end else if (!steady && $urandom_range(0, 99) < 25) begin
            out_if.ready <= 1'b0;
            sink_hold <= idle_len() - 1;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (in_if.valid && in_if.ready)
                sb.note_item(in_if.command, in_if.channel, in_if.sample, in_if.frame_end);
            if (out_if.valid && out_if.ready)
                sb.check_result(out_if.out_channel, out_if.level_db, out_if.silent,
                                out_if.last);
            if (cfg_if.valid && cfg_if.ready)
                sb.note_config(cfg_if.index, cfg_if.data);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("Watchdog: no transaction for %0d cycles", IDLE_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic send_item(input logic cmd, input logic [plmd_pkg::CHAN_W-1:0] ch,
                             input logic signed [plmd_pkg::SAMPLE_BITS-1:0] smp,
                             input logic fe);
        int gap;
        gap = (steady || $urandom_range(0, 99) < 55) ? 0 : idle_len();
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.command   <= cmd;
        in_if.channel   <= ch;
        in_if.sample    <= smp;
        in_if.frame_end <= fe;
        in_if.valid     <= 1'b1;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
    endtask

    task automatic send_tick();
        send_item(1'b1, plmd_pkg::CHAN_W'($urandom), pick_sample(), 1'($urandom));
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [plmd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [plmd_pkg::CFG_DATA_W-1:0] data);
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        cfg_if.valid <= 1'b1;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_regs(input logic [plmd_pkg::ACTIVE_W-1:0] act,
                            input logic [plmd_pkg::DECAY_W-1:0] dec);
        drain();
        write_reg(plmd_pkg::REG_ACTIVE_CHANNELS,
                  (plmd_pkg::CFG_DATA_W'($urandom) & ~plmd_pkg::CFG_DATA_W'(4'hF)) | act);
        write_reg(plmd_pkg::REG_DECAY_PER_FRAME, dec);
    endtask

    task automatic run_phase(input int n_items, input int tick_pct, input int frame_width,
                             input int fe_pct, input int zero_pct);
        int sent;
        int r;
        int c;
        logic signed [plmd_pkg::SAMPLE_BITS-1:0] smp;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            if (r < tick_pct) begin
                send_tick();
                sent++;
            end else if (r < 75) begin
                for (c = 0; c < frame_width; c++) begin
                    send_item(1'b0, plmd_pkg::CHAN_W'(c), pick_sample(), c == frame_width - 1);
                    sent++;
                end
            end else begin
                smp = ($urandom_range(0, 99) < zero_pct) ? '0 : pick_sample();
                send_item(1'b0, plmd_pkg::CHAN_W'($urandom), smp,
                          $urandom_range(0, 99) < fe_pct);
                sent++;
            end
        end
        send_tick();
    endtask

    initial begin
        sb = new();
        rst_n            = 1'b0;
        steady           = 1'b0;
        sink_hold        = 0;
        quiet_cycles     = 0;
        in_if.valid      = 1'b0;
        in_if.command    = 1'b0;
        in_if.channel    = '0;
        in_if.sample     = '0;
        in_if.frame_end  = 1'b0;
        out_if.ready     = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = '0;
        cfg_if.data      = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // A tick straight after reset reports silence on every active channel.
        send_tick();
        send_item(1'b0, 3'd0, 24'sh7FFFFF, 1'b0);
        send_item(1'b0, 3'd1, 24'sh800000, 1'b1);
        send_item(1'b0, 3'd0, 24'sh000001, 1'b0);
        send_tick();
        send_item(1'b0, 3'd0, 24'sh000001, 1'b0);
        send_item(1'b0, 3'd1, -24'sh000001, 1'b1);
        send_tick();

        set_regs(4'd8, 24'd0);
        send_item(1'b0, 3'd2, 24'sh400000, 1'b0);
        send_item(1'b0, 3'd3, -24'sh200001, 1'b0);
        send_item(1'b0, 3'd4, 24'sh000100, 1'b0);
        send_item(1'b0, 3'd5, 24'sh0ABCDE, 1'b0);
        send_item(1'b0, 3'd6, -24'sh7FFFFF, 1'b0);
        send_item(1'b0, 3'd7, 24'sh155555, 1'b1);
        send_tick();

        // Peaks of channels outside the active range are cleared by a tick.
        set_regs(4'd1, plmd_pkg::DECAY_RESET);
        send_item(1'b0, 3'd5, 24'sh7FFFFF, 1'b1);
        send_tick();
        set_regs(4'd0, 24'hFFFFFF);
        send_tick();
        set_regs(4'd15, 24'hFFFFFF);
        send_item(1'b0, 3'd0, 24'sh000000, 1'b1);
        send_item(1'b0, 3'd3, 24'sh000000, 1'b1);
        send_tick();

        set_regs(4'd8, plmd_pkg::DECAY_RESET);
        run_phase(100, 5, 8, 30, 20);

        set_regs(4'd0, 24'd0);
        steady = 1'b1;
        run_phase(60, 6, 1, 50, 10);
        steady = 1'b0;

        set_regs(4'd15, 24'hFFFFFF);
        run_phase(90, 3, 2, 85, 50);

        set_regs(plmd_pkg::ACTIVE_W'($urandom_range(1, 8)), plmd_pkg::DECAY_W'($urandom));
        run_phase(90, 5, 4, 40, 20);

        set_regs(4'd1, plmd_pkg::DECAY_W'($urandom_range(0, 65535)));
        write_reg(REG_UNUSED, plmd_pkg::CFG_DATA_W'($urandom));
        run_phase(50, 8, 3, 40, 20);

        set_regs(plmd_pkg::ACTIVE_W'(5), 24'hFFFFFF);
        run_phase(50, 5, 5, 70, 40);

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));
        $display("Run covered %0d samples and %0d ticks over %0d register writes.",
                 sb.n_samples, sb.n_ticks, sb.n_writes);
        $display("Checked %0d channel results, %0d of them silent; %0d mismatches.",
                 sb.n_results, sb.n_silent, sb.errors);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
